@@ rtl/nrld_pkg.sv @@
// ----------------------------------------------------------------------------
// Nibble run-length decoder package
// Shared types, constants and the palette lookup for the decoder modules.
// ----------------------------------------------------------------------------
package nrld_pkg;

  localparam int POSITION_BITS_DEF = 18;
  localparam int CFG_WIDTH         = 18;
  localparam int START_WIDTH       = 18;
  localparam int LEN_WIDTH         = 12;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [CFG_WIDTH-1:0] IMAGE_PIXELS_RST = 18'd220160;

  // Nibble codes.
  localparam logic [3:0] NIB_MAX_COLOR  = 4'd9;
  localparam logic [3:0] NIB_RUN_MAX    = 4'd13;
  localparam logic [3:0] NIB_CODE_SHORT = 4'd14;
  localparam logic [LEN_WIDTH-1:0] RUN_BIAS = 12'd7;

  typedef enum logic [5:0] {
    PH_CODE  = 6'b000001,
    PH_COLOR = 6'b000010,
    PH_SHORT = 6'b000100,
    PH_LONG0 = 6'b001000,
    PH_LONG1 = 6'b010000,
    PH_LONG2 = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [LEN_WIDTH-1:0] len;
    logic [3:0]           color;
  } run_t;

  // Decoder state after one nibble, and the run it completed if any.
  typedef struct packed {
    phase_t               phase;
    logic [LEN_WIDTH-1:0] count;
    logic                 emit;
    run_t                 run;
  } step_t;

  // One queue entry per accepted byte that yields runs or ends the image.
  typedef struct packed {
    run_t run0;
    run_t run1;
    logic has_run;
    logic two_runs;
    logic clear_pos;
  } qent_t;

  typedef struct packed {
    logic [START_WIDTH-1:0] run_start;
    logic [LEN_WIDTH-1:0]   run_length;
    logic [3:0]             color_nibble;
    logic [3:0]             palette_index;
    logic                   bad_color;
    logic                   overflow;
    logic                   last_of_byte;
  } result_t;

  function automatic logic [3:0] palette_lookup(input logic [3:0] color);
    logic [3:0] pal;
    unique case (color)
      4'd0:    pal = 4'd0;
      4'd1:    pal = 4'd9;
      4'd2:    pal = 4'd4;
      4'd3:    pal = 4'd11;
      4'd4:    pal = 4'd7;
      4'd5:    pal = 4'd8;
      4'd6:    pal = 4'd5;
      4'd7:    pal = 4'd10;
      4'd8:    pal = 4'd14;
      4'd9:    pal = 4'd15;
      default: pal = 4'd0;
    endcase
    return pal;
  endfunction

endpackage

@@ rtl/nibble_run_length_decoder.sv @@
// ----------------------------------------------------------------------------
// Nibble run-length decoder
// Reads a nibble-coded image one byte per transfer and returns one run
// descriptor per completed code.
//
// Input: push a byte with in_push while in_full is low; in_last_byte marks
// the final byte of an image, after which the code state and pixel position
// return to their reset values and an unfinished code is dropped.
// Output: while out_empty is low the oldest descriptor is on the out_ ports;
// out_pop takes it. Each byte yields zero, one or two descriptors, the last
// of them marked by out_last_of_byte.
// Entries are registered in the queue, runs in the output register. The
// front end takes one byte per cycle while in_full is low; the back end
// places one run per cycle while its output register is free. A four-entry
// queue sits between them, and in_full rises only when that queue is full,
// which happens when the receiver stalls or two-run bytes arrive faster
// than the back end drains them.
// cfg_wr_en writes the image size (reset 220160) from cfg_wr_data.
// Reset is synchronous, active low, and empties the queue and the output.
// ----------------------------------------------------------------------------
module nibble_run_length_decoder #(
  parameter int POSITION_BITS = nrld_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [nrld_pkg::CFG_WIDTH-1:0]   cfg_wr_data,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_last_byte,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [nrld_pkg::START_WIDTH-1:0] out_run_start,
  output logic [nrld_pkg::LEN_WIDTH-1:0]   out_run_length,
  output logic [3:0]                       out_color_nibble,
  output logic [3:0]                       out_palette_index,
  output logic                             out_bad_color,
  output logic                             out_overflow,
  output logic                             out_last_of_byte
);

  logic [nrld_pkg::CFG_WIDTH-1:0] image_pixels_r;
  logic                           q_push, q_pop, q_empty, q_full;
  logic                           in_accept, out_take, out_valid;
  nrld_pkg::qent_t                q_in, q_head;
  nrld_pkg::result_t              result;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;
  assign out_empty = !out_valid;
  assign out_take  = out_pop && out_valid;

  assign out_run_start     = result.run_start;
  assign out_run_length    = result.run_length;
  assign out_color_nibble  = result.color_nibble;
  assign out_palette_index = result.palette_index;
  assign out_bad_color     = result.bad_color;
  assign out_overflow      = result.overflow;
  assign out_last_of_byte  = result.last_of_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_pixels_r <= nrld_pkg::IMAGE_PIXELS_RST;
    end else if (cfg_wr_en) begin
      image_pixels_r <= cfg_wr_data;
    end
  end

  nrld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .push      (q_push),
    .entry     (q_in)
  );

  nrld_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  nrld_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_pixels (image_pixels_r),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_take     (out_take),
    .out_valid    (out_valid),
    .result       (result)
  );

endmodule

@@ rtl/nrld_front.sv @@
// ----------------------------------------------------------------------------
// Nibble run-length decoder front end
// Decodes both nibbles of an accepted byte combinationally and pushes the
// completed runs, as one queue entry, toward the back end.
// ----------------------------------------------------------------------------
module nrld_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output logic           push,
  output nrld_pkg::qent_t entry
);

  nrld_pkg::phase_t                    phase_r, phase_nxt;
  logic [nrld_pkg::LEN_WIDTH-1:0]      count_r, count_nxt;
  nrld_pkg::step_t                     hi_step, lo_step;

  function automatic nrld_pkg::step_t nib_step(
    input nrld_pkg::phase_t               ph,
    input logic [nrld_pkg::LEN_WIDTH-1:0] cnt,
    input logic [3:0]                     nib
  );
    nrld_pkg::step_t s;
    s.phase     = nrld_pkg::PH_CODE;
    s.count     = cnt;
    s.emit      = 1'b0;
    s.run.len   = cnt;
    s.run.color = nib;
    unique case (ph)
      nrld_pkg::PH_COLOR: begin
        s.emit  = 1'b1;
        s.count = '0;
      end
      nrld_pkg::PH_SHORT: begin
        s.count = nrld_pkg::LEN_WIDTH'(nib) + nrld_pkg::RUN_BIAS;
        s.phase = nrld_pkg::PH_COLOR;
      end
      nrld_pkg::PH_LONG0: begin
        s.count = nrld_pkg::LEN_WIDTH'(nib);
        s.phase = nrld_pkg::PH_LONG1;
      end
      nrld_pkg::PH_LONG1: begin
        s.count = {cnt[11:8], nib, cnt[3:0]};
        s.phase = nrld_pkg::PH_LONG2;
      end
      nrld_pkg::PH_LONG2: begin
        s.count = {nib, cnt[7:0]};
        s.phase = nrld_pkg::PH_COLOR;
      end
      default: begin
        // Expecting a code nibble: a color alone is a single pixel.
        if (nib <= nrld_pkg::NIB_MAX_COLOR) begin
          s.emit    = 1'b1;
          s.run.len = nrld_pkg::LEN_WIDTH'(1);
          s.count   = '0;
        end else if (nib <= nrld_pkg::NIB_RUN_MAX) begin
          s.count = nrld_pkg::LEN_WIDTH'(nib) - nrld_pkg::RUN_BIAS;
          s.phase = nrld_pkg::PH_COLOR;
        end else if (nib == nrld_pkg::NIB_CODE_SHORT) begin
          s.phase = nrld_pkg::PH_SHORT;
        end else begin
          s.phase = nrld_pkg::PH_LONG0;
        end
      end
    endcase
    return s;
  endfunction

  always_comb begin
    hi_step = nib_step(phase_r, count_r, data_byte[7:4]);
    lo_step = nib_step(hi_step.phase, hi_step.count, data_byte[3:0]);

    entry.has_run   = hi_step.emit | lo_step.emit;
    entry.two_runs  = hi_step.emit & lo_step.emit;
    entry.run0      = hi_step.emit ? hi_step.run : lo_step.run;
    entry.run1      = lo_step.run;
    entry.clear_pos = last_byte;

    push = accept & (entry.has_run | last_byte);

    phase_nxt = phase_r;
    count_nxt = count_r;
    if (accept) begin
      if (last_byte) begin
        // An unfinished code at the end of the image is dropped.
        phase_nxt = nrld_pkg::PH_CODE;
        count_nxt = '0;
      end else begin
        phase_nxt = lo_step.phase;
        count_nxt = lo_step.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= nrld_pkg::PH_CODE;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/nrld_queue.sv @@
// ----------------------------------------------------------------------------
// Nibble run-length decoder entry queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module nrld_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nrld_pkg::qent_t push_entry,
  input  logic            pop,
  output nrld_pkg::qent_t head,
  output logic            empty,
  output logic            full
);

  localparam int Depth = nrld_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(Depth);

  nrld_pkg::qent_t entries_r [Depth];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (AW+1)'(Depth));
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/nrld_back.sv @@
// ----------------------------------------------------------------------------
// Nibble run-length decoder back end
// Places queued runs in the image, checks them against the image size and
// holds one finished run descriptor in the output register.
// ----------------------------------------------------------------------------
module nrld_back #(
  parameter int POSITION_BITS = nrld_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [nrld_pkg::CFG_WIDTH-1:0]   image_pixels,
  input  nrld_pkg::qent_t                  head,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  logic                             out_take,
  output logic                             out_valid,
  output nrld_pkg::result_t                result
);

  localparam int SW = POSITION_BITS + nrld_pkg::LEN_WIDTH + 1;

  logic [POSITION_BITS-1:0]                          pos_r, pos_nxt;
  logic                                              sel_r, sel_nxt;
  logic                                              out_valid_r, out_valid_nxt;
  nrld_pkg::result_t                                 res_r, res_nxt;
  nrld_pkg::run_t                                    cur;
  logic                                              last_slot;
  logic                                              out_load;
  logic                                              fire_run;
  logic [SW-1:0]                                     sum;
  logic [POSITION_BITS+nrld_pkg::START_WIDTH-1:0]    start_ext;

  assign out_valid = out_valid_r;
  assign result    = res_r;

  always_comb begin
    cur       = sel_r ? head.run1 : head.run0;
    last_slot = !head.two_runs || sel_r;
    sum       = SW'(pos_r) + SW'(cur.len);
    start_ext = {{nrld_pkg::START_WIDTH{1'b0}}, pos_r};
    out_load  = !out_valid_r || out_take;
    fire_run  = !q_empty && head.has_run && out_load;
    // An entry without runs only carries the end-of-image position clear.
    q_pop     = !q_empty && (!head.has_run || (out_load && last_slot));

    res_nxt.run_start     = start_ext[nrld_pkg::START_WIDTH-1:0];
    res_nxt.run_length    = cur.len;
    res_nxt.color_nibble  = cur.color;
    res_nxt.palette_index = nrld_pkg::palette_lookup(cur.color);
    res_nxt.bad_color     = (cur.color > nrld_pkg::NIB_MAX_COLOR);
    res_nxt.overflow      = (sum > SW'(image_pixels));
    res_nxt.last_of_byte  = last_slot;

    pos_nxt = pos_r;
    if (q_pop && head.clear_pos) begin
      pos_nxt = '0;
    end else if (fire_run) begin
      pos_nxt = sum[POSITION_BITS-1:0];
    end

    sel_nxt = sel_r;
    if (fire_run) begin
      sel_nxt = !last_slot;
    end

    out_valid_nxt = out_valid_r;
    if (fire_run) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_run) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ tb/sv/nrld_run_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble run-length decoder checker
// Watches the byte, descriptor and size-register ports of the decoder. It
// decodes every accepted byte itself, queues the run descriptors it
// expects, and compares each descriptor the receiver takes with the oldest
// of them.
// ----------------------------------------------------------------------------
module nrld_run_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [nrld_pkg::CFG_WIDTH-1:0]   cfg_wr_data,
  input  logic                             in_push,
  input  logic                             in_full,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_last_byte,
  input  logic                             out_empty,
  input  logic                             out_pop,
  input  logic [nrld_pkg::START_WIDTH-1:0] out_run_start,
  input  logic [nrld_pkg::LEN_WIDTH-1:0]   out_run_length,
  input  logic [3:0]                       out_color_nibble,
  input  logic [3:0]                       out_palette_index,
  input  logic                             out_bad_color,
  input  logic                             out_overflow,
  input  logic                             out_last_of_byte,
  output int                               mismatch_count,
  output int                               runs_pending
);

  // Palette entry for each valid color, color 0 in the low nibble.
  localparam logic [39:0] PALETTE_MAP = {4'd15, 4'd14, 4'd10, 4'd5, 4'd8,
                                         4'd7, 4'd11, 4'd4, 4'd9, 4'd0};

  nrld_pkg::phase_t                 phase;
  logic [nrld_pkg::LEN_WIDTH-1:0]   run_count;
  logic [nrld_pkg::START_WIDTH-1:0] position;
  logic [nrld_pkg::CFG_WIDTH-1:0]   image_size;
  nrld_pkg::result_t                expected_runs[$];

  task automatic place_run(input logic [3:0] color, output nrld_pkg::result_t r);
    logic [nrld_pkg::START_WIDTH:0] run_end;
    run_end = {1'b0, position} + run_count;
    r.run_start     = position;
    r.run_length    = run_count;
    r.color_nibble  = color;
    r.bad_color     = color > nrld_pkg::NIB_MAX_COLOR;
    r.palette_index = r.bad_color ? 4'd0 : PALETTE_MAP[color*4 +: 4];
    r.overflow      = run_end > {1'b0, image_size};
    r.last_of_byte  = 1'b0;
    // The position wraps at the width of the start index.
    position = run_end[nrld_pkg::START_WIDTH-1:0];
  endtask

  task automatic decode_nibble(input logic [3:0] nib, output logic emitted,
                               output nrld_pkg::result_t r);
    emitted = 1'b0;
    r = '0;
    case (phase)
      nrld_pkg::PH_COLOR: begin
        place_run(nib, r);
        emitted   = 1'b1;
        run_count = '0;
        phase     = nrld_pkg::PH_CODE;
      end
      nrld_pkg::PH_SHORT: begin
        run_count = nib + nrld_pkg::RUN_BIAS;
        phase     = nrld_pkg::PH_COLOR;
      end
      nrld_pkg::PH_LONG0: begin
        run_count = {8'd0, nib};
        phase     = nrld_pkg::PH_LONG1;
      end
      nrld_pkg::PH_LONG1: begin
        run_count[7:4] = nib;
        phase          = nrld_pkg::PH_LONG2;
      end
      nrld_pkg::PH_LONG2: begin
        run_count[11:8] = nib;
        phase           = nrld_pkg::PH_COLOR;
      end
      default: begin
        if (nib <= nrld_pkg::NIB_MAX_COLOR) begin
          run_count = 12'd1;
          place_run(nib, r);
          emitted   = 1'b1;
          run_count = '0;
          phase     = nrld_pkg::PH_CODE;
        end else if (nib <= nrld_pkg::NIB_RUN_MAX) begin
          run_count = {8'd0, nib} - nrld_pkg::RUN_BIAS;
          phase     = nrld_pkg::PH_COLOR;
        end else if (nib == nrld_pkg::NIB_CODE_SHORT) begin
          phase = nrld_pkg::PH_SHORT;
        end else begin
          phase = nrld_pkg::PH_LONG0;
        end
      end
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] data, input logic last);
    logic              hi_emit;
    logic              lo_emit;
    nrld_pkg::result_t hi_run;
    nrld_pkg::result_t lo_run;
    decode_nibble(data[7:4], hi_emit, hi_run);
    decode_nibble(data[3:0], lo_emit, lo_run);
    if (lo_emit) begin
      lo_run.last_of_byte = 1'b1;
    end else begin
      hi_run.last_of_byte = 1'b1;
    end
    if (hi_emit) begin
      expected_runs.push_back(hi_run);
    end
    if (lo_emit) begin
      expected_runs.push_back(lo_run);
    end
    // The final byte of an image drops any unfinished code.
    if (last) begin
      phase     = nrld_pkg::PH_CODE;
      run_count = '0;
      position  = '0;
    end
  endtask

  task automatic check_run();
    nrld_pkg::result_t seen;
    nrld_pkg::result_t want;
    seen.run_start     = out_run_start;
    seen.run_length    = out_run_length;
    seen.color_nibble  = out_color_nibble;
    seen.palette_index = out_palette_index;
    seen.bad_color     = out_bad_color;
    seen.overflow      = out_overflow;
    seen.last_of_byte  = out_last_of_byte;
    if (expected_runs.size() == 0) begin
      $display("%0t: unexpected run start=%0d len=%0d color=%0d", $time,
               seen.run_start, seen.run_length, seen.color_nibble);
      mismatch_count++;
    end else begin
      want = expected_runs.pop_front();
      if (seen !== want) begin
        $display("%0t: run mismatch expected start=%0d len=%0d color=%0d pal=%0d",
                 $time, want.run_start, want.run_length, want.color_nibble,
                 want.palette_index, " bad=%0b ovf=%0b last=%0b",
                 want.bad_color, want.overflow, want.last_of_byte);
        $display("%0t:              actual start=%0d len=%0d color=%0d pal=%0d",
                 $time, seen.run_start, seen.run_length, seen.color_nibble,
                 seen.palette_index, " bad=%0b ovf=%0b last=%0b",
                 seen.bad_color, seen.overflow, seen.last_of_byte);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase          = nrld_pkg::PH_CODE;
      run_count      = '0;
      position       = '0;
      image_size     = nrld_pkg::IMAGE_PIXELS_RST;
      mismatch_count = 0;
      expected_runs.delete();
    end else begin
      if (cfg_wr_en) begin
        image_size = cfg_wr_data;
      end
      if (out_pop && !out_empty) begin
        check_run();
      end
      if (in_push && !in_full) begin
        predict_byte(in_data_byte, in_last_byte);
      end
    end
    runs_pending = expected_runs.size();
  end

endmodule

@@ tb/sv/nibble_run_length_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nibble run-length decoder testbench
// Feeds directed bytes for each code form and special case, then phases of
// random code streams under several image sizes and idle patterns on both
// channels. The checker beside the block predicts and compares descriptors.
// ----------------------------------------------------------------------------
module nibble_run_length_decoder_test;

  localparam logic [3:0] NIB_CODE_LONG = nrld_pkg::NIB_CODE_SHORT + 4'd1;
  localparam int STALL_LIMIT     = 2000;
  localparam int BYTES_PER_PHASE = 325;
  localparam int MODE_SPAN       = 80;
  localparam int SETTLE_CYCLES   = 8;
  localparam int IDLE_PCT        = 58;
  localparam int BOTH_IDLE_PCT   = 6;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [nrld_pkg::CFG_WIDTH-1:0]   cfg_wr_data = '0;
  logic                             in_push = 1'b0;
  logic                             in_full;
  logic [7:0]                       in_data_byte = '0;
  logic                             in_last_byte = 1'b0;
  logic                             out_empty;
  logic                             out_pop = 1'b0;
  logic [nrld_pkg::START_WIDTH-1:0] out_run_start;
  logic [nrld_pkg::LEN_WIDTH-1:0]   out_run_length;
  logic [3:0]                       out_color_nibble;
  logic [3:0]                       out_palette_index;
  logic                             out_bad_color;
  logic                             out_overflow;
  logic                             out_last_of_byte;

  int         mismatch_count;
  int         runs_pending;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles = 0;
  int         random_bytes = 0;
  logic [3:0] nibble_q[$];

  nibble_run_length_decoder u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_run_start     (out_run_start),
    .out_run_length    (out_run_length),
    .out_color_nibble  (out_color_nibble),
    .out_palette_index (out_palette_index),
    .out_bad_color     (out_bad_color),
    .out_overflow      (out_overflow),
    .out_last_of_byte  (out_last_of_byte)
  );

  nrld_run_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_run_start     (out_run_start),
    .out_run_length    (out_run_length),
    .out_color_nibble  (out_color_nibble),
    .out_palette_index (out_palette_index),
    .out_bad_color     (out_bad_color),
    .out_overflow      (out_overflow),
    .out_last_of_byte  (out_last_of_byte),
    .mismatch_count    (mismatch_count),
    .runs_pending      (runs_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Ends the run if neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic set_idle_mode(input int mode);
    case (mode)
      1: begin
        send_idle_pct  = IDLE_PCT;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = IDLE_PCT;
      end
      3: begin
        send_idle_pct  = BOTH_IDLE_PCT;
        recv_stall_pct = BOTH_IDLE_PCT;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (in_full);
  endtask

  // The size register may only change once every descriptor is out and the
  // back end has had time to retire bytes that carry no run.
  task automatic write_size(input logic [nrld_pkg::CFG_WIDTH-1:0] value);
    in_push <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Appends one code to the nibble stream: mostly well-formed codes with
  // random content, some lone random nibbles as noise.
  task automatic add_code(input int long_pct, input bit full_count);
    int                             kind;
    logic [3:0]                     color;
    logic [nrld_pkg::LEN_WIDTH-1:0] count;
    kind  = $urandom_range(99);
    color = 4'(($urandom_range(9) == 0)
               ? $urandom_range(15, nrld_pkg::NIB_MAX_COLOR + 1)
               : $urandom_range(nrld_pkg::NIB_MAX_COLOR));
    if (kind < 10) begin
      nibble_q.push_back(4'($urandom_range(15)));
    end else if (kind < 10 + long_pct) begin
      case ($urandom_range(7))
        0:       count = '0;
        1:       count = '1;
        default: count = nrld_pkg::LEN_WIDTH'($urandom_range(4095));
      endcase
      if (full_count) begin
        count = '1;
      end
      nibble_q.push_back(NIB_CODE_LONG);
      nibble_q.push_back(count[3:0]);
      nibble_q.push_back(count[7:4]);
      nibble_q.push_back(count[11:8]);
      nibble_q.push_back(color);
    end else begin
      case ($urandom_range(2))
        0: nibble_q.push_back(4'($urandom_range(nrld_pkg::NIB_MAX_COLOR)));
        1: begin
          nibble_q.push_back(4'($urandom_range(nrld_pkg::NIB_RUN_MAX,
                                               nrld_pkg::NIB_MAX_COLOR + 1)));
          nibble_q.push_back(color);
        end
        default: begin
          nibble_q.push_back(nrld_pkg::NIB_CODE_SHORT);
          nibble_q.push_back(4'($urandom_range(15)));
          nibble_q.push_back(color);
        end
      endcase
    end
  endtask

  task automatic run_phase(input logic [nrld_pkg::CFG_WIDTH-1:0] size,
                           input int long_pct, input bit full_count,
                           input int last_per_mille);
    int         phase_bytes;
    logic [3:0] hi;
    logic [3:0] lo;
    phase_bytes = 0;
    write_size(size);
    while (phase_bytes < BYTES_PER_PHASE) begin
      add_code(long_pct, full_count);
      while (nibble_q.size() >= 2) begin
        set_idle_mode((random_bytes / MODE_SPAN) % 4);
        hi = nibble_q.pop_front();
        lo = nibble_q.pop_front();
        send_byte({hi, lo}, $urandom_range(999) < last_per_mille);
        random_bytes++;
        phase_bytes++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Every code form under the reset image size: single pixels, short runs,
    // bad colors, the biased count, a zero-length and a maximum long run.
    send_byte(8'h09, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h71, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h38, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h9B, 1'b0);
    send_byte(8'h45, 1'b1);

    // A one-pixel image: overflow, and final bytes that cut codes short.
    write_size(18'd1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h0E, 1'b1);
    send_byte(8'hF1, 1'b1);
    send_byte(8'hE5, 1'b1);
    send_byte(8'h33, 1'b0);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hC0, 1'b0);

    // The first phase sends mostly maximum long runs so the position wraps.
    run_phase('1, 90, 1'b1, 0);
    run_phase(18'd1, 10, 1'b0, 20);
    run_phase(nrld_pkg::CFG_WIDTH'($urandom_range(400, 1)), 10, 1'b0, 20);
    run_phase(nrld_pkg::CFG_WIDTH'($urandom_range(262143, 1)), 10, 1'b0, 20);
    run_phase(nrld_pkg::IMAGE_PIXELS_RST, 10, 1'b0, 20);
    run_phase(nrld_pkg::CFG_WIDTH'($urandom_range(5000, 1000)), 10, 1'b0, 20);

    in_push <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && runs_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
